### hdl/bitmap_page_allocator_next_fit_top_macros.svh
// assertion macros shared by the page allocator rtl
// no dependencies; included by the modules that carry assertions
`ifndef BITMAP_PAGE_ALLOCATOR_NEXT_FIT_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_NEXT_FIT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// check that is switched off while reset is held
`define BPA_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define BPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPA_ASSERT_RST(label, clk, rst_n, prop, msg)
`define BPA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### hdl/bpa_pkg.sv
// shared types and constants of the bitmap page allocator
// no dependencies; imported by every module of the block
package bpa_pkg;

    // bitmap memory word geometry
    localparam int WORD_BITS = 32;
    localparam int WORD_LOG = 5;

    // page frame geometry
    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_BITS = 20;
    localparam int ADDR_BITS = 32;
    localparam int PAGES_BITS = 11;

    // configuration port
    localparam int CFG_DATA_W = 20;
    localparam logic [FRAME_BITS-1:0] BASE_RESET = 20'd1024;
    localparam logic [PAGES_BITS-1:0] PAGES_RESET = 11'd1024;

    typedef enum logic {
        CFG_BASE  = 1'b0,
        CFG_PAGES = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_FULL    = 2'd1,
        ST_FREED   = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef struct packed {
        t_action               action;
        logic [ADDR_BITS-1:0]  page_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  alloc_addr;
        t_status               status;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic start;
        logic init;
        logic rd_en;
        logic wr_en;
        logic next_word;
        logic set_full;
        logic set_outside;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic free_ok;
        logic n_zero;
        logic found;
        logic scan_end;
    } t_sts;

endpackage

### hdl/bpa_ctrl.sv
// controller state machine of the bitmap page allocator
// depends on bpa_pkg and the assertion macro header
`include "bitmap_page_allocator_next_fit_top_macros.svh"

module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  bpa_pkg::t_sts  i_sts,
    output bpa_pkg::t_cmd  o_cmd
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_EVAL,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.start = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.init = 1'b1;
                if (i_sts.is_free) begin
                    if (!i_sts.free_ok) begin
                        cmd.set_outside = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (i_sts.n_zero) begin
                    cmd.set_full = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.is_free || i_sts.found) begin
                    cmd.wr_en = 1'b1;
                    n_state = S_FIN;
                end else if (i_sts.scan_end) begin
                    cmd.set_full = 1'b1;
                    n_state = S_FIN;
                end else begin
                    cmd.next_word = 1'b1;
                    n_state = S_READ;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_rsp_ready) begin
                    cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd = cmd;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    `BPA_ASSERT_RST(a_accept_dispatch, i_clk, i_rst_n, (o_req_ready && i_req_valid) |=> (r_state == S_DISPATCH), "accepted request did not dispatch")
    `BPA_ASSERT_RST(a_rise_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_FIN), "result shown outside finish")
    `BPA_ASSERT_ALWAYS(a_reset_clear, i_clk, (!i_rst_n) |=> (!r_out_valid && r_state == S_CLEAR), "reset did not restart clearing")

endmodule

### hdl/bpa_dpath.sv
// datapath of the bitmap page allocator: config, bitmap memory, scan logic
// depends on bpa_pkg and the assertion macro header
`include "bitmap_page_allocator_next_fit_top_macros.svh"

module bpa_dpath #(
    parameter int MAX_POOL_PAGES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  bpa_pkg::t_cfg_idx              i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bpa_pkg::t_req                  i_req,
    input  bpa_pkg::t_cmd                  i_cmd,
    output bpa_pkg::t_sts                  o_sts,
    output bpa_pkg::t_rsp                  o_rsp
);
    import bpa_pkg::*;

    localparam int WORDS = (MAX_POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW = AW + WORD_LOG;
    localparam int CW = IW + 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [FRAME_BITS:0] MAX_PAGES_W = (FRAME_BITS + 1)'(MAX_POOL_PAGES);
    localparam logic [WORD_BITS-1:0] ALL1 = '1;

    // configuration and control registers
    logic [FRAME_BITS-1:0] r_base;
    logic [PAGES_BITS-1:0] r_pages;
    logic [CW-1:0]         r_cursor;
    logic [AW-1:0]         r_clr;

    // payload registers
    logic [CW-1:0]         r_n;
    t_req                  r_req;
    logic [AW-1:0]         r_w;
    logic [IW-1:0]         r_lo;
    logic                  r_phase2;
    logic [WORD_LOG-1:0]   r_bit;
    t_rsp                  r_res;
    t_rsp                  r_out;
    logic [WORD_BITS-1:0]  r_rd;
    logic [WORD_BITS-1:0]  r_mem [WORDS];

    logic [FRAME_BITS:0]   room;
    logic [FRAME_BITS:0]   pages_ext;
    logic [FRAME_BITS:0]   n_a;
    logic [FRAME_BITS:0]   n_b;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] off;
    logic                  free_ok;
    logic [IW-1:0]         off_idx;
    logic [IW-1:0]         lo_init;
    logic [CW-1:0]         n_m1;
    logic [AW-1:0]         last_w;
    logic [WORD_BITS-1:0]  lo_mask;
    logic [WORD_BITS-1:0]  hi_mask;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  sel;
    logic [WORD_LOG-1:0]   sel_idx;
    logic [IW-1:0]         page_idx;
    logic [FRAME_BITS-1:0] found_frame;
    logic                  is_alloc;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [WORD_BITS-1:0]  mem_wd;

    // effective pool size, saturated to the memory depth and the frame limit
    assign room = {1'b1, {FRAME_BITS{1'b0}}} - {1'b0, r_base};
    assign pages_ext = (FRAME_BITS + 1)'(r_pages);
    assign n_a = (pages_ext < MAX_PAGES_W) ? pages_ext : MAX_PAGES_W;
    assign n_b = (n_a < room) ? n_a : room;

    // free address decode
    assign frame = r_req.page_addr[ADDR_BITS-1:FRAME_SHIFT];
    assign off = frame - r_base;
    assign free_ok = (frame >= r_base) && ({1'b0, off} < (FRAME_BITS + 1)'(r_n));
    assign off_idx = off[IW-1:0];

    // scan start, restarting at the bottom when the cursor is outside the pool
    assign lo_init = (r_cursor >= r_n) ? '0 : r_cursor[IW-1:0];
    assign n_m1 = r_n - CW'(1);
    assign last_w = n_m1[IW-1:WORD_LOG];

    // candidate free bits of the current word
    assign lo_mask = (r_w == r_lo[IW-1:WORD_LOG]) ? (ALL1 << r_lo[WORD_LOG-1:0]) : ALL1;
    assign hi_mask = ({1'b0, r_w} == r_n[CW-1:WORD_LOG]) ?
                     ~(ALL1 << r_n[WORD_LOG-1:0]) : ALL1;
    assign cand = ~r_rd & lo_mask & hi_mask;
    assign sel = cand & (~cand + 32'd1);

    // lowest candidate to bit index
    always_comb begin
        sel_idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            sel_idx = sel_idx | (WORD_LOG'(b) & {WORD_LOG{sel[b]}});
        end
    end

    assign page_idx = {r_w, sel_idx};
    assign found_frame = r_base + FRAME_BITS'(page_idx);
    assign is_alloc = (r_req.action == ACT_ALLOC);

    // config registers, cursor and clearing pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_pages <= PAGES_RESET;
            r_cursor <= '0;
            r_clr <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base <= i_cfg_data;
                    CFG_PAGES: r_pages <= i_cfg_data[PAGES_BITS-1:0];
                    default:   r_base <= r_base;
                endcase
            end
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.set_full) begin
                r_cursor <= r_n;
            end else if (i_cmd.next_word && (r_w == last_w) && !r_phase2) begin
                r_cursor <= r_n;
            end else if (i_cmd.wr_en && is_alloc && !r_phase2) begin
                r_cursor <= CW'(page_idx);
            end
        end
    end

    // scan state and results
    always_ff @(posedge i_clk) begin
        r_n <= n_b[CW-1:0];
        if (i_cmd.start) begin
            r_req <= i_req;
        end
        if (i_cmd.init) begin
            r_phase2 <= 1'b0;
            if (r_req.action == ACT_FREE) begin
                r_w <= off_idx[IW-1:WORD_LOG];
                r_bit <= off_idx[WORD_LOG-1:0];
            end else begin
                r_w <= lo_init[IW-1:WORD_LOG];
                r_lo <= lo_init;
            end
        end
        if (i_cmd.next_word) begin
            if ((r_w == last_w) && !r_phase2) begin
                r_phase2 <= 1'b1;
                r_w <= '0;
                r_lo <= '0;
            end else begin
                r_w <= r_w + AW'(1);
            end
        end
        if (i_cmd.wr_en) begin
            if (is_alloc) begin
                r_res <= '{alloc_addr: {found_frame, {FRAME_SHIFT{1'b0}}}, status: ST_ALLOC};
            end else begin
                r_res <= '{alloc_addr: '0, status: ST_FREED};
            end
        end
        if (i_cmd.set_full) begin
            r_res <= '{alloc_addr: '0, status: ST_FULL};
        end
        if (i_cmd.set_outside) begin
            r_res <= '{alloc_addr: '0, status: ST_OUTSIDE};
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    // bitmap memory: clearing sweep, set on allocate, clear on free
    assign mem_we = i_cmd.clr_en | i_cmd.wr_en;
    assign mem_wa = i_cmd.clr_en ? r_clr : r_w;
    assign mem_wd = i_cmd.clr_en ? '0 :
                    is_alloc ? (r_rd | sel) : (r_rd & ~(WORD_BITS'(1) << r_bit));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_w];
        end
    end

    // status to the controller
    assign o_sts.clr_done = (r_clr == LAST_WORD);
    assign o_sts.is_free = (r_req.action == ACT_FREE);
    assign o_sts.free_ok = free_ok;
    assign o_sts.n_zero = (r_n == '0);
    assign o_sts.found = |cand;
    assign o_sts.scan_end = r_phase2 && (r_w == last_w);
    assign o_rsp = r_out;

    `BPA_ASSERT_RST(a_rd_in_range, i_clk, i_rst_n, i_cmd.rd_en |-> (r_w <= LAST_WORD), "bitmap read past depth")
    `BPA_ASSERT_RST(a_alloc_bit_free, i_clk, i_rst_n, (i_cmd.wr_en && is_alloc) |-> ((|cand) && ((r_rd & sel) == '0)), "allocated a used page")
    `BPA_ASSERT_RST(a_cursor_in_pool, i_clk, i_rst_n, (i_cmd.wr_en && is_alloc && !r_phase2) |=> (r_cursor < r_n), "cursor left outside pool")

endmodule

### hdl/bitmap_page_allocator_next_fit_top.sv
// top level of the next-fit bitmap page allocator
// depends on bpa_pkg, bpa_ctrl and bpa_dpath
//
//   channel   direction  payload                        handshake
//   req       in         t_req {action, page_addr}      i_req_valid / o_req_ready
//   rsp       out        t_rsp {alloc_addr, status}     o_rsp_valid / i_rsp_ready
//   cfg       in         i_cfg_index, i_cfg_data        i_cfg_valid / o_cfg_ready
//
// request to request: a free steps through idle, dispatch, read, evaluate and finish,
// but skips read and evaluate for a page outside the pool; an allocate has a read and
// an evaluate per word scanned, none on an empty pool, up to a partial and a full pass.
// after reset a clearing pass writes ceil(MAX_POOL_PAGES/32) words, one per cycle,
// before the first request is taken; config writes are taken during it.
// a result waits in the output register; the next request is taken meanwhile and its
// finish step holds until the previous result is read.
module bitmap_page_allocator_next_fit_top #(
    parameter int MAX_POOL_PAGES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  bpa_pkg::t_req                  i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output bpa_pkg::t_rsp                  o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  bpa_pkg::t_cfg_idx              i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // the user must write config only while idle; the block does not enforce it, so writes are always taken
    assign o_cfg_ready = 1'b1;

    // controller
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    bpa_dpath #(
        .MAX_POOL_PAGES (MAX_POOL_PAGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule
